### rtl/core/ehfx_pkg.sv
package ehfx_pkg;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_ELF    = 3'd1,
        ST_TRUNCATED  = 3'd2,
        ST_BAD_ENDIAN = 3'd3,
        ST_BAD_CLASS  = 3'd4
    } t_status;

    localparam logic [3:0] FID_IS64      = 4'd0;
    localparam logic [3:0] FID_BIG       = 4'd1;
    localparam logic [3:0] FID_TYPE      = 4'd2;
    localparam logic [3:0] FID_MACHINE   = 4'd3;
    localparam logic [3:0] FID_ENTRY     = 4'd4;
    localparam logic [3:0] FID_PHOFF     = 4'd5;
    localparam logic [3:0] FID_SHOFF     = 4'd6;
    localparam logic [3:0] FID_PHNUM     = 4'd7;
    localparam logic [3:0] FID_SHNUM     = 4'd8;
    localparam logic [3:0] FID_SHSTRNDX  = 4'd9;
    localparam logic [3:0] FID_EHSIZE    = 4'd10;
    localparam logic [3:0] FID_SHENTSIZE = 4'd11;

    localparam logic [5:0] MAGIC_LEN  = 6'd4;
    localparam logic [5:0] OFF_CLASS  = 6'd4;
    localparam logic [5:0] OFF_DATA   = 6'd5;
    localparam logic [5:0] IDENT_LAST = 6'd15;
    localparam logic [5:0] HDR32_LAST = 6'd51;
    localparam logic [5:0] HDR64_LAST = 6'd63;

    localparam logic [7:0] CLASS_32 = 8'd1;
    localparam logic [7:0] CLASS_64 = 8'd2;
    localparam logic [7:0] DATA_LSB = 8'd1;
    localparam logic [7:0] DATA_MSB = 8'd2;

    typedef struct packed {
        logic [15:0] e_type;
        logic [15:0] machine;
        logic [63:0] entry;
        logic [63:0] phoff;
        logic [63:0] shoff;
        logic [15:0] phnum;
        logic [15:0] shnum;
        logic [15:0] shstrndx;
        logic [15:0] ehsize;
        logic [15:0] shentsize;
    } t_fields;

    typedef struct packed {
        t_status status;
        logic    is64;
        logic    big;
        t_fields f;
    } t_job;

    typedef struct packed {
        logic       hit;
        logic [3:0] fid;
        logic [2:0] idx;
        logic [2:0] len_m1;
    } t_place;

    function automatic logic [7:0] magic_byte(input logic [1:0] i);
        logic [7:0] m;
        unique case (i)
            2'd0: m = 8'h7F;
            2'd1: m = 8'h45;
            2'd2: m = 8'h4C;
            default: m = 8'h46;
        endcase
        return m;
    endfunction

    // Map a header offset to its field, byte index within the field and length less one.
    function automatic t_place place_of(input logic [5:0] p, input logic is64);
        t_place r;
        r        = '0;
        r.hit    = 1'b1;
        r.len_m1 = 3'd1;
        r.idx    = {2'b00, p[0]};
        if (is64) begin
            unique case (p) inside
                [6'd16:6'd17]: r.fid = FID_TYPE;
                [6'd18:6'd19]: r.fid = FID_MACHINE;
                [6'd24:6'd31]: begin
                    r.fid = FID_ENTRY; r.len_m1 = 3'd7; r.idx = p[2:0];
                end
                [6'd32:6'd39]: begin
                    r.fid = FID_PHOFF; r.len_m1 = 3'd7; r.idx = p[2:0];
                end
                [6'd40:6'd47]: begin
                    r.fid = FID_SHOFF; r.len_m1 = 3'd7; r.idx = p[2:0];
                end
                [6'd52:6'd53]: r.fid = FID_EHSIZE;
                [6'd56:6'd57]: r.fid = FID_PHNUM;
                [6'd58:6'd59]: r.fid = FID_SHENTSIZE;
                [6'd60:6'd61]: r.fid = FID_SHNUM;
                [6'd62:6'd63]: r.fid = FID_SHSTRNDX;
                default: r.hit = 1'b0;
            endcase
        end else begin
            unique case (p) inside
                [6'd16:6'd17]: r.fid = FID_TYPE;
                [6'd18:6'd19]: r.fid = FID_MACHINE;
                [6'd24:6'd27]: begin
                    r.fid = FID_ENTRY; r.len_m1 = 3'd3; r.idx = {1'b0, p[1:0]};
                end
                [6'd28:6'd31]: begin
                    r.fid = FID_PHOFF; r.len_m1 = 3'd3; r.idx = {1'b0, p[1:0]};
                end
                [6'd32:6'd35]: begin
                    r.fid = FID_SHOFF; r.len_m1 = 3'd3; r.idx = {1'b0, p[1:0]};
                end
                [6'd40:6'd41]: r.fid = FID_EHSIZE;
                [6'd44:6'd45]: r.fid = FID_PHNUM;
                [6'd46:6'd47]: r.fid = FID_SHENTSIZE;
                [6'd48:6'd49]: r.fid = FID_SHNUM;
                [6'd50:6'd51]: r.fid = FID_SHSTRNDX;
                default: r.hit = 1'b0;
            endcase
        end
        return r;
    endfunction

endpackage

### rtl/core/elf_header_field_extractor_top.sv
// Channel   Direction  Handshake                 Beat payload
// -------   ---------  ------------------------  -----------------------------------------
// in        sink       i_in_valid / o_in_ready    i_data_byte, i_end_of_file
// out       source     o_out_valid / i_out_ready  o_status, o_field_id, o_field_value,
//                                                 o_last_of_run
//
// Input takes one byte per cycle; o_in_ready drops only while the job queue is full.
// A decoded header leaves as 12 output beats, an error as 1 beat; the back end's beat
// counter steps through them, one beat per cycle while i_out_ready is high.
// A result job is queued in the cycle after its deciding byte; its first beat shows
// once the back end pops it. Reset is synchronous, active low, with no clearing pass.
// Output stalls back up through the job queue only; input stalls never touch the output.
module elf_header_field_extractor_top #(
    parameter int QUEUE_DEPTH = ehfx_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [3:0]  o_field_id,
    output logic [63:0] o_field_value,
    output logic        o_last_of_run
);

    // Jobs from the classifier to the result sequencer.
    logic           w_push;
    logic           w_full;
    logic           w_q_valid;
    logic           w_pop;
    ehfx_pkg::t_job w_job_in;
    ehfx_pkg::t_job w_job_out;

    // Front: check magic and ident, assemble fields in the chosen byte order,
    // and push one job per file when its outcome is known.
    ehfx_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .o_push        (w_push),
        .o_job         (w_job_in),
        .i_full        (w_full)
    );

    // Hold finished jobs so the next file streams in while results drain.
    ehfx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_data  (w_job_out)
    );

    // Back: step through the field beats of the current job.
    ehfx_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (w_q_valid),
        .i_job         (w_job_out),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_field_id    (o_field_id),
        .o_field_value (o_field_value),
        .o_last_of_run (o_last_of_run)
    );

endmodule

### rtl/core/ehfx_front.sv
module ehfx_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_end_of_file,
    output logic                o_push,
    output ehfx_pkg::t_job      o_job,
    input  logic                i_full
);

    logic [5:0]        r_pos, n_pos;
    logic              r_decided, n_decided;
    logic              r_is64, n_is64;
    logic              r_big, n_big;
    logic [7:0]        r_cls, n_cls;
    logic [7:0]        r_enc, n_enc;
    ehfx_pkg::t_fields r_fields, n_fields;
    ehfx_pkg::t_place  w_place;
    ehfx_pkg::t_status w_status;
    logic [2:0]        w_sh;
    logic [5:0]        w_last;
    logic              w_take;
    logic              w_result;

    assign o_in_ready = !i_full;
    assign w_take     = i_in_valid && o_in_ready;
    assign w_place    = ehfx_pkg::place_of(r_pos, r_is64);
    assign w_sh       = r_big ? (w_place.len_m1 - w_place.idx) : w_place.idx;
    assign w_last     = r_is64 ? ehfx_pkg::HDR64_LAST : ehfx_pkg::HDR32_LAST;

    always_comb begin
        n_pos     = r_pos;
        n_decided = r_decided;
        n_is64    = r_is64;
        n_big     = r_big;
        n_cls     = r_cls;
        n_enc     = r_enc;
        n_fields  = r_fields;
        w_result  = 1'b0;
        w_status  = ehfx_pkg::ST_OK;
        if (w_take) begin
            if (!r_decided) begin
                if (r_pos == '0) begin
                    n_fields = '0;
                end
                if (r_pos == ehfx_pkg::OFF_CLASS) begin
                    n_cls = i_data_byte;
                end
                if (r_pos == ehfx_pkg::OFF_DATA) begin
                    n_enc = i_data_byte;
                end
                if (w_place.hit) begin
                    unique case (w_place.fid)
                        ehfx_pkg::FID_TYPE:
                            n_fields.e_type[{w_sh[0], 3'b000} +: 8] = i_data_byte;
                        ehfx_pkg::FID_MACHINE:
                            n_fields.machine[{w_sh[0], 3'b000} +: 8] = i_data_byte;
                        ehfx_pkg::FID_ENTRY:
                            n_fields.entry[{w_sh, 3'b000} +: 8] = i_data_byte;
                        ehfx_pkg::FID_PHOFF:
                            n_fields.phoff[{w_sh, 3'b000} +: 8] = i_data_byte;
                        ehfx_pkg::FID_SHOFF:
                            n_fields.shoff[{w_sh, 3'b000} +: 8] = i_data_byte;
                        ehfx_pkg::FID_PHNUM:
                            n_fields.phnum[{w_sh[0], 3'b000} +: 8] = i_data_byte;
                        ehfx_pkg::FID_SHNUM:
                            n_fields.shnum[{w_sh[0], 3'b000} +: 8] = i_data_byte;
                        ehfx_pkg::FID_SHSTRNDX:
                            n_fields.shstrndx[{w_sh[0], 3'b000} +: 8] = i_data_byte;
                        ehfx_pkg::FID_EHSIZE:
                            n_fields.ehsize[{w_sh[0], 3'b000} +: 8] = i_data_byte;
                        ehfx_pkg::FID_SHENTSIZE:
                            n_fields.shentsize[{w_sh[0], 3'b000} +: 8] = i_data_byte;
                        default: ;
                    endcase
                end

                if (r_pos < ehfx_pkg::MAGIC_LEN &&
                    i_data_byte != ehfx_pkg::magic_byte(r_pos[1:0])) begin
                    w_result = 1'b1;
                    w_status = ehfx_pkg::ST_NOT_ELF;
                end else if (r_pos == ehfx_pkg::IDENT_LAST) begin
                    if (r_enc != ehfx_pkg::DATA_LSB && r_enc != ehfx_pkg::DATA_MSB) begin
                        w_result = 1'b1;
                        w_status = ehfx_pkg::ST_BAD_ENDIAN;
                    end else if (r_cls != ehfx_pkg::CLASS_32 &&
                                 r_cls != ehfx_pkg::CLASS_64) begin
                        w_result = 1'b1;
                        w_status = ehfx_pkg::ST_BAD_CLASS;
                    end else begin
                        n_big  = (r_enc == ehfx_pkg::DATA_MSB);
                        n_is64 = (r_cls == ehfx_pkg::CLASS_64);
                    end
                end else if (r_pos > ehfx_pkg::IDENT_LAST && r_pos == w_last) begin
                    w_result = 1'b1;
                end

                // End mark with nothing decided yet: short file.
                if (!w_result && i_end_of_file) begin
                    w_result = 1'b1;
                    w_status = (r_pos < ehfx_pkg::MAGIC_LEN - 6'd1) ?
                               ehfx_pkg::ST_NOT_ELF : ehfx_pkg::ST_TRUNCATED;
                end

                n_pos = r_pos + 6'd1;
                if (!i_end_of_file && w_result) begin
                    n_decided = 1'b1;
                end
            end
            if (i_end_of_file) begin
                n_pos     = '0;
                n_decided = 1'b0;
                n_is64    = 1'b0;
                n_big     = 1'b0;
            end
        end
    end

    assign o_push      = w_take && w_result;
    assign o_job.status = w_status;
    assign o_job.is64  = r_is64;
    assign o_job.big   = r_big;
    assign o_job.f     = n_fields;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_decided <= 1'b0;
            r_is64    <= 1'b0;
            r_big     <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_decided <= n_decided;
            r_is64    <= n_is64;
            r_big     <= n_big;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls    <= n_cls;
        r_enc    <= n_enc;
        r_fields <= n_fields;
    end

endmodule

### rtl/core/ehfx_queue.sv
module ehfx_queue #(
    parameter int DEPTH = ehfx_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ehfx_pkg::t_job i_data,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output ehfx_pkg::t_job o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ehfx_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wr, n_wr;
    logic [AW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           w_push, w_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + AW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + AW'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### rtl/core/ehfx_back.sv
module ehfx_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  ehfx_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [2:0]     o_status,
    output logic [3:0]     o_field_id,
    output logic [63:0]    o_field_value,
    output logic           o_last_of_run
);

    ehfx_pkg::t_job r_cur;
    logic           r_busy, n_busy;
    logic [3:0]     r_idx, n_idx;
    logic           w_err, w_last, w_fire;
    logic [63:0]    w_value;

    assign w_err  = (r_cur.status != ehfx_pkg::ST_OK);
    assign w_last = w_err || (r_idx == ehfx_pkg::FID_SHENTSIZE);
    assign w_fire = r_busy && i_out_ready;
    assign o_pop  = i_job_valid && (!r_busy || (w_fire && w_last));

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = ehfx_pkg::FID_IS64;
        end else if (w_fire && w_last) begin
            n_busy = 1'b0;
        end else if (w_fire) begin
            n_idx = r_idx + 4'd1;
        end
    end

    always_comb begin
        unique case (r_idx)
            ehfx_pkg::FID_IS64:      w_value = {63'd0, r_cur.is64};
            ehfx_pkg::FID_BIG:       w_value = {63'd0, r_cur.big};
            ehfx_pkg::FID_TYPE:      w_value = {48'd0, r_cur.f.e_type};
            ehfx_pkg::FID_MACHINE:   w_value = {48'd0, r_cur.f.machine};
            ehfx_pkg::FID_ENTRY:     w_value = r_cur.f.entry;
            ehfx_pkg::FID_PHOFF:     w_value = r_cur.f.phoff;
            ehfx_pkg::FID_SHOFF:     w_value = r_cur.f.shoff;
            ehfx_pkg::FID_PHNUM:     w_value = {48'd0, r_cur.f.phnum};
            ehfx_pkg::FID_SHNUM:     w_value = {48'd0, r_cur.f.shnum};
            ehfx_pkg::FID_SHSTRNDX:  w_value = {48'd0, r_cur.f.shstrndx};
            ehfx_pkg::FID_EHSIZE:    w_value = {48'd0, r_cur.f.ehsize};
            ehfx_pkg::FID_SHENTSIZE: w_value = {48'd0, r_cur.f.shentsize};
            default:                 w_value = '0;
        endcase
    end

    assign o_out_valid   = r_busy;
    assign o_status      = r_cur.status;
    assign o_field_id    = w_err ? ehfx_pkg::FID_IS64 : r_idx;
    assign o_field_value = w_err ? 64'd0 : w_value;
    assign o_last_of_run = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_job;
        end
    end

endmodule

### rtl/core/ehfx_chk.sv
module ehfx_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_status,
    input logic [3:0]  o_field_id,
    input logic [63:0] o_field_value,
    input logic        o_last_of_run
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_field_value)
            && $stable(o_field_id) && $stable(o_status))
        else $error("output beat dropped or changed while stalled");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ehfx_pkg::ST_OK |->
            o_last_of_run && o_field_id == ehfx_pkg::FID_IS64 && o_field_value == 64'd0)
        else $error("error beat is not a single zeroed beat");

    a_ok_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ehfx_pkg::ST_OK |->
            o_last_of_run == (o_field_id == ehfx_pkg::FID_SHENTSIZE))
        else $error("run end mark on wrong field");

    a_ok_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_status == ehfx_pkg::ST_OK && !o_last_of_run |=>
            o_out_valid && o_status == ehfx_pkg::ST_OK
            && o_field_id == 4'($past(o_field_id) + 4'd1))
        else $error("field run broken or out of order");

endmodule

bind elf_header_field_extractor_top ehfx_chk u_chk (.*);
